// ===== src/rbst_pkg.sv =====
// shared types, constants and the quotient saturation helper for the ray box slab test
// no dependencies; used by every module of the block by scoped names
package rbst_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned LANES     = 2 * AXES;
  localparam int unsigned QW        = 32;
  localparam int unsigned BW        = 34;
  localparam int unsigned DW        = 35;
  localparam int unsigned REMW      = 50;
  localparam int unsigned EPSW      = 16;
  localparam int unsigned HALFW     = 31;
  localparam int unsigned SHW       = 6;
  localparam int unsigned DIV_STEPS = QW + 1;
  localparam int unsigned IN_W      = 2 * AXES * QW;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned IDXW      = 3;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [BW-1:0] bnd_t;

  typedef enum logic [IDXW-1:0] {
    REG_CTR_X = 3'd0,
    REG_CTR_Y = 3'd1,
    REG_CTR_Z = 3'd2,
    REG_HALF_X = 3'd3,
    REG_HALF_Y = 3'd4,
    REG_HALF_Z = 3'd5,
    REG_EPS   = 3'd6,
    REG_NONE  = 3'd7
  } reg_idx_e;

  // one divider lane: partial remainder, divisor magnitude, quotient bits
  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [QW-1:0]   dvs;
    logic [QW-1:0]   quo;
    logic            ovf;
    logic            neg;
  } lane_t;

  // lane 2a is the low plane of axis a, lane 2a+1 the high plane
  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [AXES-1:0]   par;
    logic [AXES-1:0]   pmiss;
  } div_t;

  function automatic q_t sat_q(lane_t l);
    q_t r;
    if (l.neg) begin
      if (l.ovf || (l.quo > 32'h8000_0000)) r = Q_MIN;
      else r = q_t'(-l.quo);
    end else begin
      if (l.ovf || l.quo[QW-1]) r = Q_MAX;
      else r = q_t'(l.quo);
    end
    return r;
  endfunction

endpackage

// ===== src/rbst_prep.sv =====
// front stage: plane distances, scaled numerators, divisor magnitudes, parallel checks
// depends on rbst_pkg
module rbst_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rbst_pkg::q_t              org_i [rbst_pkg::AXES],
  input  rbst_pkg::q_t              dir_i [rbst_pkg::AXES],
  input  rbst_pkg::bnd_t            lo_i  [rbst_pkg::AXES],
  input  rbst_pkg::bnd_t            hi_i  [rbst_pkg::AXES],
  input  logic [rbst_pkg::EPSW-1:0] eps_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rbst_pkg::div_t            out_data_o
);

  logic           valid_q;
  rbst_pkg::div_t data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    logic signed [rbst_pkg::DW-1:0] dlo, dhi, eps_s;
    logic [rbst_pkg::QW:0]          adir;
    logic [rbst_pkg::BW-1:0]        mlo, mhi;
    data_d = '0;
    eps_s  = signed'({{(rbst_pkg::DW - rbst_pkg::EPSW){1'b0}}, eps_i});
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      dlo  = rbst_pkg::DW'(lo_i[a]) - rbst_pkg::DW'(org_i[a]);
      dhi  = rbst_pkg::DW'(hi_i[a]) - rbst_pkg::DW'(org_i[a]);
      adir = dir_i[a][rbst_pkg::QW-1] ? (rbst_pkg::QW+1)'(-((rbst_pkg::QW+1)'(dir_i[a])))
                                      : (rbst_pkg::QW+1)'(dir_i[a]);
      mlo  = dlo[rbst_pkg::DW-1] ? rbst_pkg::BW'(-dlo) : rbst_pkg::BW'(dlo);
      mhi  = dhi[rbst_pkg::DW-1] ? rbst_pkg::BW'(-dhi) : rbst_pkg::BW'(dhi);
      data_d.par[a]   = (dir_i[a] == '0) || (adir < (rbst_pkg::QW+1)'(eps_i));
      data_d.pmiss[a] = ((rbst_pkg::DW'(0) - dlo) < eps_s) || (dhi < eps_s);
      data_d.lane[2*a].rem   = {mlo, 16'b0};
      data_d.lane[2*a+1].rem = {mhi, 16'b0};
      data_d.lane[2*a].neg   = dlo[rbst_pkg::DW-1] ^ dir_i[a][rbst_pkg::QW-1];
      data_d.lane[2*a+1].neg = dhi[rbst_pkg::DW-1] ^ dir_i[a][rbst_pkg::QW-1];
      // parallel axes divide by one so the lanes stay well defined
      data_d.lane[2*a].dvs   = data_d.par[a] ? rbst_pkg::QW'(1) : adir[rbst_pkg::QW-1:0];
      data_d.lane[2*a+1].dvs = data_d.lane[2*a].dvs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/rbst_div_step.sv =====
// one restoring division step on all six lanes, with its stage register
// depends on rbst_pkg; shift 32 is the overflow probe, 31..0 yield quotient bits
module rbst_div_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rbst_pkg::SHW-1:0] shift_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rbst_pkg::div_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rbst_pkg::div_t           out_data_o
);

  localparam int unsigned CW = 2 * rbst_pkg::QW;

  logic           valid_q;
  rbst_pkg::div_t data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    logic [CW-1:0] sh;
    logic          ge;
    data_d = in_data_i;
    for (int l = 0; l < rbst_pkg::LANES; l++) begin
      sh = {{(CW - rbst_pkg::QW){1'b0}}, in_data_i.lane[l].dvs} << shift_i;
      ge = CW'(in_data_i.lane[l].rem) >= sh;
      if (ge) begin
        if (shift_i == rbst_pkg::SHW'(rbst_pkg::QW)) begin
          data_d.lane[l].ovf = 1'b1;
        end else begin
          data_d.lane[l].rem = in_data_i.lane[l].rem - sh[rbst_pkg::REMW-1:0];
          data_d.lane[l].quo[shift_i[rbst_pkg::SHW-2:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/rbst_resolve.sv =====
// back end: saturate and order the slab times, then fold them into the hit flag
// depends on rbst_pkg; two register stages, the second is the output register
module rbst_resolve (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rbst_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           hit_o
);

  logic                      a_valid_q, b_valid_q, a_ready, b_ready;
  rbst_pkg::q_t              tlo_d [rbst_pkg::AXES];
  rbst_pkg::q_t              thi_d [rbst_pkg::AXES];
  rbst_pkg::q_t              tlo_q [rbst_pkg::AXES];
  rbst_pkg::q_t              thi_q [rbst_pkg::AXES];
  logic [rbst_pkg::AXES-1:0] par_q, pmiss_q;
  logic                      hit_d, hit_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    rbst_pkg::q_t t1, t2;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      t1 = rbst_pkg::sat_q(in_data_i.lane[2*a]);
      t2 = rbst_pkg::sat_q(in_data_i.lane[2*a+1]);
      tlo_d[a] = (t1 > t2) ? t2 : t1;
      thi_d[a] = (t1 > t2) ? t1 : t2;
    end
  end

  // near starts at zero, far at the format maximum; parallel axes do not bound t
  always_comb begin
    rbst_pkg::q_t near_t, far_t;
    near_t = '0;
    far_t  = rbst_pkg::Q_MAX;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      if (!par_q[a]) begin
        if (tlo_q[a] > near_t) near_t = tlo_q[a];
        if (thi_q[a] < far_t) far_t = thi_q[a];
      end
    end
    hit_d = !(|(par_q & pmiss_q)) && (near_t <= far_t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      tlo_q   <= tlo_d;
      thi_q   <= thi_d;
      par_q   <= in_data_i.par;
      pmiss_q <= in_data_i.pmiss;
    end
    if (b_ready && a_valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign hit_o       = hit_q;

endmodule

// ===== src/ray_box_slab_test.sv =====
// top level of the ray versus box slab test: config registers, bounds, pipeline chain
// depends on rbst_pkg, rbst_prep, rbst_div_step, rbst_resolve
//
//  channel   dir  beat fields (lowest bit first)
//  s_axis    in   origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 b each)
//  m_axis    out  hit (bit 0, bits 7:1 zero)
//  cfg       in   write enable, register index 0..6, 32 b write data
//
// input beat to result beat passes one prep stage, one overflow probe, 32 restoring
// division steps (one quotient bit each) and two resolve stages; one ray can enter
// every cycle while the chain has room; every stage has its own valid bit and ready,
// so bubbles close up and input keeps flowing while a result waits at the output
// reset clears all valid bits and sets centers and half extents to 0, epsilon to 1
// box bounds are registered from the new register values at the write edge itself
module ray_box_slab_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbst_pkg::IDXW-1:0]  cfg_idx_i,
  input  logic [rbst_pkg::QW-1:0]    cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [rbst_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // hit, then zero fill
  output logic [rbst_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned NSTG = rbst_pkg::DIV_STEPS + 1;

  // configuration registers
  rbst_pkg::q_t                 ctr_q  [rbst_pkg::AXES];
  logic [rbst_pkg::HALFW-1:0]   half_q [rbst_pkg::AXES];
  logic [rbst_pkg::EPSW-1:0]    eps_q;
  rbst_pkg::q_t                 ctr_d  [rbst_pkg::AXES];
  logic [rbst_pkg::HALFW-1:0]   half_d [rbst_pkg::AXES];
  logic [rbst_pkg::EPSW-1:0]    eps_d;
  // slab planes, kept at full width so nothing wraps
  rbst_pkg::bnd_t               lo_q [rbst_pkg::AXES];
  rbst_pkg::bnd_t               hi_q [rbst_pkg::AXES];

  rbst_pkg::q_t                 org  [rbst_pkg::AXES];
  rbst_pkg::q_t                 dir  [rbst_pkg::AXES];

  // pipeline links: index 0 leaves prep, index NSTG-1 enters resolve
  logic                         stg_valid [NSTG];
  logic                         stg_ready [NSTG];
  rbst_pkg::div_t               stg_data  [NSTG];
  logic                         hit;

  // next register values, so the planes can follow a write in the same edge
  always_comb begin
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      ctr_d[a]  = ctr_q[a];
      half_d[a] = half_q[a];
    end
    eps_d = eps_q;
    if (cfg_we_i) begin
      case (rbst_pkg::reg_idx_e'(cfg_idx_i))
        rbst_pkg::REG_CTR_X:  ctr_d[0]  = cfg_wdata_i;
        rbst_pkg::REG_CTR_Y:  ctr_d[1]  = cfg_wdata_i;
        rbst_pkg::REG_CTR_Z:  ctr_d[2]  = cfg_wdata_i;
        rbst_pkg::REG_HALF_X: half_d[0] = cfg_wdata_i[rbst_pkg::HALFW-1:0];
        rbst_pkg::REG_HALF_Y: half_d[1] = cfg_wdata_i[rbst_pkg::HALFW-1:0];
        rbst_pkg::REG_HALF_Z: half_d[2] = cfg_wdata_i[rbst_pkg::HALFW-1:0];
        rbst_pkg::REG_EPS:    eps_d     = cfg_wdata_i[rbst_pkg::EPSW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
        ctr_q[a]  <= '0;
        half_q[a] <= '0;
        lo_q[a]   <= '0;
        hi_q[a]   <= '0;
      end
      eps_q <= rbst_pkg::EPSW'(1);
    end else begin
      for (int a = 0; a < rbst_pkg::AXES; a++) begin
        ctr_q[a]  <= ctr_d[a];
        half_q[a] <= half_d[a];
        lo_q[a]   <= rbst_pkg::BW'(ctr_d[a]) - signed'({3'b0, half_d[a]});
        hi_q[a]   <= rbst_pkg::BW'(ctr_d[a]) + signed'({3'b0, half_d[a]});
      end
      eps_q <= eps_d;
    end
  end

  // unpack the ray beat
  always_comb begin
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      org[a] = s_axis_tdata[rbst_pkg::QW*a +: rbst_pkg::QW];
      dir[a] = s_axis_tdata[rbst_pkg::QW*(rbst_pkg::AXES+a) +: rbst_pkg::QW];
    end
  end

  rbst_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .org_i       (org),
    .dir_i       (dir),
    .lo_i        (lo_q),
    .hi_i        (hi_q),
    .eps_i       (eps_q),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_data_o  (stg_data[0])
  );

  // overflow probe first (shift 32), then quotient bits 31 down to 0
  for (genvar k = 0; k < rbst_pkg::DIV_STEPS; k++) begin : g_div
    rbst_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (rbst_pkg::SHW'(rbst_pkg::QW - k)),
      .in_valid_i  (stg_valid[k]),
      .in_ready_o  (stg_ready[k]),
      .in_data_i   (stg_data[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_ready_i (stg_ready[k+1]),
      .out_data_o  (stg_data[k+1])
    );
  end

  rbst_resolve u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[NSTG-1]),
    .in_ready_o  (stg_ready[NSTG-1]),
    .in_data_i   (stg_data[NSTG-1]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (hit)
  );

  assign m_axis_tdata = {{(rbst_pkg::OUT_W-1){1'b0}}, hit};

  // the input only stalls when the whole chain is full behind a blocked result
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output side can drain");

  // the x low plane always matches the x center and half extent registers
  a_plane_tracks_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q[0] == (rbst_pkg::BW'(ctr_q[0]) - signed'({3'b0, half_q[0]})))
    else $error("x low plane does not match configuration");

endmodule
